[src/alid_pkg.sv]
// shared constants and types for the array list insert/delete core
package alid_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VAL_W = 32;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [VAL_W-1:0] t_val;

    // operation codes
    localparam logic [1:0] OP_DELETE = 2'd0;
    localparam logic [1:0] OP_FRONT  = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_AT_POS = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    // one memory access request from the sequencer
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_val wdata;
        t_idx raddr;
    } t_mem_req;

endpackage

[src/array_list_insert_delete_core.sv]
// array list core: ordered list with insert, append, delete and full readout
// an insert moves later entries up one place, a delete searches for the value and on a hit closes the gap,
// rejects go straight to readout; then one result per entry (one for an empty list), each in the
// cycle after its read; one item per run, the next accepted only once busy drops; the longest run
// is a delete on a full list, set by the single read port that search, moves and readout share
// results cannot be stalled; busy drops in the cycle that shows the last result
// reset (i_rst_n low, synchronous) empties the list and returns the sequencer to idle
module array_list_insert_delete_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_op,
    input  logic signed [31:0]      i_value,
    input  logic [4:0]              i_position,
    output logic                    o_strobe,
    output logic signed [31:0]      o_element,
    output logic [3:0]              o_element_index,
    output logic [1:0]              o_status,
    output logic                    o_is_empty,
    output logic                    o_last
);
    import alid_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    t_cnt       r_cnt, n_cnt;
    t_idx       r_idx, n_idx;
    t_idx       r_tgt, n_tgt;
    t_val       r_val, n_val;
    logic       r_ph, n_ph;
    logic [1:0] r_status, n_status;
    logic       r_pend, n_pend;
    logic       r_plast, n_plast;
    logic       r_pempty, n_pempty;
    t_idx       r_pidx, n_pidx;

    t_mem_req   w_req;
    t_val       w_rdata;
    logic       w_idx_last;

    alid_store u_store (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rdata(w_rdata)
    );

    // r_idx is the final valid entry
    assign w_idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_tgt    = r_tgt;
        n_val    = r_val;
        n_ph     = r_ph;
        n_status = r_status;
        n_pend   = 1'b0;
        n_plast  = r_plast;
        n_pempty = r_pempty;
        n_pidx   = r_pidx;
        w_req    = '{we: 1'b0, waddr: r_idx, wdata: w_rdata, raddr: r_idx};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val    = i_value;
                    n_ph     = 1'b0;
                    n_status = ST_OK;
                    if (i_op == OP_DELETE) begin
                        n_idx = '0;
                        if (r_cnt == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end else if (r_cnt == CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                        n_idx    = '0;
                        n_state  = S_OUT;
                    end else if (i_op == OP_AT_POS && CNT_W'(i_position) > r_cnt) begin
                        n_status = ST_BAD_POS;
                        n_idx    = '0;
                        n_state  = S_OUT;
                    end else begin
                        n_idx   = r_cnt[IDX_W-1:0];
                        n_state = S_INS;
                        case (i_op)
                            OP_FRONT:  n_tgt = '0;
                            OP_APPEND: n_tgt = r_cnt[IDX_W-1:0];
                            default:   n_tgt = i_position[IDX_W-1:0];
                        endcase
                    end
                end
            end

            // move entries up one place, then drop the new value in
            S_INS: begin
                if (r_idx == r_tgt) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_tgt;
                    w_req.wdata = r_val;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_idx       = '0;
                    n_state     = S_OUT;
                end else if (!r_ph) begin
                    w_req.raddr = r_idx - IDX_W'(1);
                    n_ph        = 1'b1;
                end else begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_idx;
                    w_req.wdata = w_rdata;
                    n_idx       = r_idx - IDX_W'(1);
                    n_ph        = 1'b0;
                end
            end

            // look for the first match, one entry per read
            S_SRCH: begin
                if (!r_ph) begin
                    w_req.raddr = r_idx;
                    n_ph        = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (w_rdata == r_val) begin
                        n_state = S_DEL;
                    end else if (w_idx_last) begin
                        n_status = ST_NOT_FOUND;
                        n_idx    = '0;
                        n_state  = S_OUT;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            // close the gap by moving later entries down
            S_DEL: begin
                if (w_idx_last) begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_idx   = '0;
                    n_state = S_OUT;
                end else if (!r_ph) begin
                    w_req.raddr = r_idx + IDX_W'(1);
                    n_ph        = 1'b1;
                end else begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_idx;
                    w_req.wdata = w_rdata;
                    n_idx       = r_idx + IDX_W'(1);
                    n_ph        = 1'b0;
                end
            end

            // stream the list, read data lands in the next cycle
            S_OUT: begin
                w_req.raddr = r_idx;
                n_pend      = 1'b1;
                n_pidx      = r_idx;
                if (r_cnt == '0) begin
                    n_pempty = 1'b1;
                    n_plast  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_pempty = 1'b0;
                    n_plast  = w_idx_last;
                    n_idx    = r_idx + IDX_W'(1);
                    if (w_idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_ph    <= n_ph;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_val    <= n_val;
        r_status <= n_status;
        r_plast  <= n_plast;
        r_pempty <= n_pempty;
        r_pidx   <= n_pidx;
    end

    // result ports
    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_pend;
    assign o_element       = r_pempty ? '0 : w_rdata;
    assign o_element_index = r_pempty ? 4'd0 : r_pidx[3:0];
    assign o_status        = r_status;
    assign o_is_empty      = r_pempty;
    assign o_last          = r_plast;

endmodule

[src/alid_store.sv]
// list storage: one write port, one read port with registered read data
module alid_store (
    input  logic              i_clk,
    input  alid_pkg::t_mem_req i_req,
    output alid_pkg::t_val    o_rdata
);
    import alid_pkg::*;

    t_val r_mem [DEPTH];
    t_val r_rdata;

    // write and synchronous read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/alid_checker.sv]
// port-level checks for the array list core, bound to the top level
module alid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic signed [31:0] o_element,
    input logic [3:0]         o_element_index,
    input logic               o_is_empty,
    input logic               o_last
);

    // an accepted item always occupies the core
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("core not busy after accepting an item");

    // empty-list result is the only and final result, with zero payload
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_empty |-> o_last && o_element == 0 && o_element_index == 4'd0)
        else $error("empty-list result malformed");

    // results of one run come back to back with rising index
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe &&
            o_element_index == 4'($past(o_element_index) + 4'd1))
        else $error("result stream broken");

    // a run in progress keeps the core busy
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("core idle in the middle of a run");

endmodule

bind array_list_insert_delete_core alid_checker u_alid_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_element      (o_element),
    .o_element_index(o_element_index),
    .o_is_empty     (o_is_empty),
    .o_last         (o_last)
);
